// File: rtl/directional_kinematic_limit_assert.svh
// Assertion macros for the directional kinematic limit block.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef DIRECTIONAL_KINEMATIC_LIMIT_ASSERT_SVH
`define DIRECTIONAL_KINEMATIC_LIMIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define DKL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define DKL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dkl_pkg.sv
// Shared constants and pipeline types for the directional kinematic limit.
// No dependencies.
package dkl_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DIR_W     = 16;
    localparam int MAG_W     = DIR_W;
    localparam int LIM_W     = 16;
    localparam int OUT_W     = 17;
    localparam int SQ_W      = 2 * DIR_W;
    localparam int VAL_W     = SQ_W + 2 * FRAC_BITS;
    localparam int RT_W      = VAL_W / 2;
    localparam int REM_W     = RT_W + 2;
    localparam int NUM_W     = LIM_W + RT_W;
    localparam int DEN_W     = RT_W;
    localparam int DSH_W     = DEN_W + OUT_W - 1;
    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    typedef struct packed {
        logic             res0;
        logic             az0;
        logic [MAG_W-1:0] az;
        logic [LIM_W-1:0] lxy;
        logic [LIM_W-1:0] zl;
    } t_side;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic [REM_W-1:0] rem;
        logic [RT_W-1:0]  root;
    } t_sq_lane;

    typedef struct packed {
        t_sq_lane h;
        t_sq_lane n;
        t_side    side;
    } t_sq;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [DSH_W-1:0] dsh;
        logic [OUT_W-1:0] q;
        logic             spec;
        logic [OUT_W-1:0] sval;
    } t_div;

endpackage

// File: rtl/dkl_if.sv
// Request and result channel interfaces for the directional kinematic limit.
// Depends on dkl_pkg.
interface dkl_in_if import dkl_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [LIM_W-1:0]        limit_xy;
    logic [LIM_W-1:0]        limit_up;
    logic [LIM_W-1:0]        limit_down;

    modport source (output valid, dir_x, dir_y, dir_z, limit_xy, limit_up, limit_down,
                    input ready);
    modport sink   (input valid, dir_x, dir_y, dir_z, limit_xy, limit_up, limit_down,
                    output ready);
endinterface

interface dkl_out_if import dkl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] limit_along;

    modport source (output valid, limit_along, input ready);
    modport sink   (input valid, limit_along, output ready);
endinterface

// File: rtl/directional_kinematic_limit.sv
// Directional kinematic limit: top level with magnitude, square, root, select,
// divide and output stages. Depends on dkl_pkg, dkl_if, both cell modules and the
// assertion macro header.
//
// Use: each request on i_req carries a direction (x, y, z, signed) and three
// unsigned Q8.8 limits (horizontal, up, down). Each request yields exactly one
// result on o_res: the largest scalar limit along the direction, Q9.8, held at
// 131071 on overflow.
// Throughput: one request per cycle while i_req.ready is high; the root and divider
// chains are fully pipelined, one root bit and one quotient bit per cell.
// Pipeline: from accept to o_res.valid the registers are input, square, 24 root
// cells, product, select, 17 divider cells and the output register.
// Stall: the output register is backed by a one-entry skid, so a request is
// still taken while a result waits; the whole pipeline holds only once the
// skid is full, and i_req.ready then drops.
// Reset: synchronous, active low; clears all valid flags, nothing in flight.
`include "directional_kinematic_limit_assert.svh"

module directional_kinematic_limit import dkl_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dkl_in_if.sink    i_req,
    dkl_out_if.source o_res
);

    // Global advance: hold every stage while the skid is occupied.
    logic r_sv;
    logic en;
    assign en          = ~r_sv;
    assign i_req.ready = en;

    // Stage 0: magnitudes, sign, zero tests, choose vertical limit.
    logic             r_s0_v;
    logic [MAG_W-1:0] r_ax;
    logic [MAG_W-1:0] r_ay;
    t_side            r_s0_side;
    t_side            n_s0_side;
    logic [MAG_W-1:0] n_ax;
    logic [MAG_W-1:0] n_ay;
    logic             zpos;

    always_comb begin
        n_ax = i_req.dir_x[DIR_W-1] ? MAG_W'(~i_req.dir_x + 1'b1) : MAG_W'(i_req.dir_x);
        n_ay = i_req.dir_y[DIR_W-1] ? MAG_W'(~i_req.dir_y + 1'b1) : MAG_W'(i_req.dir_y);
        n_s0_side.az = i_req.dir_z[DIR_W-1] ? MAG_W'(~i_req.dir_z + 1'b1)
                                            : MAG_W'(i_req.dir_z);
        zpos = ~i_req.dir_z[DIR_W-1] && (i_req.dir_z != '0);
        n_s0_side.az0  = (i_req.dir_z == '0);
        n_s0_side.lxy  = i_req.limit_xy;
        n_s0_side.zl   = zpos ? i_req.limit_up : i_req.limit_down;
        n_s0_side.res0 = (i_req.dir_x == '0 && i_req.dir_y == '0 && i_req.dir_z == '0)
                      || i_req.limit_xy == '0 || i_req.limit_up == '0
                      || i_req.limit_down == '0;
    end

    // Stage 1: squared lengths, seed both root lanes.
    logic r_s1_v;
    t_sq  r_s1;
    t_sq  n_s1;
    logic [SQ_W-1:0] hsq;
    logic [SQ_W-1:0] nsq;

    always_comb begin
        hsq = SQ_W'(r_ax * r_ax) + SQ_W'(r_ay * r_ay);
        nsq = hsq + SQ_W'(r_s0_side.az * r_s0_side.az);
        n_s1.h.val  = {hsq, {(2*FRAC_BITS){1'b0}}};
        n_s1.h.rem  = '0;
        n_s1.h.root = '0;
        n_s1.n.val  = {nsq, {(2*FRAC_BITS){1'b0}}};
        n_s1.n.rem  = '0;
        n_s1.n.root = '0;
        n_s1.side   = r_s0_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s0_v <= i_req.valid;
            r_s1_v <= r_s0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ax      <= n_ax;
            r_ay      <= n_ay;
            r_s0_side <= n_s0_side;
            r_s1      <= n_s1;
        end
    end

    // Root chain: one bit of h and n per cell.
    logic w_sq_v [0:RT_W];
    t_sq  w_sq   [0:RT_W];
    assign w_sq_v[0] = r_s1_v;
    assign w_sq[0]   = r_s1;

    for (genvar g = 0; g < RT_W; g++) begin : g_sqrt
        dkl_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_sq_v[g]),
            .i_data  (w_sq[g]),
            .o_valid (w_sq_v[g+1]),
            .o_data  (w_sq[g+1])
        );
    end

    // Stage 2: products for the slope test and both numerators.
    t_sq                  sq_end;
    logic                 r_s2_v;
    t_side                r_s2_side;
    logic [RT_W-1:0]      r_h;
    logic [2*LIM_W-1:0]   r_cl;
    logic [NUM_W-1:0]     r_cr;
    logic [NUM_W-1:0]     r_hn;
    logic [NUM_W-1:0]     r_zn;
    assign sq_end = w_sq[RT_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= w_sq_v[RT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_side <= sq_end.side;
            r_h       <= sq_end.h.root;
            r_cl      <= (2*LIM_W)'(sq_end.side.az * sq_end.side.lxy);
            r_cr      <= NUM_W'(sq_end.side.zl * sq_end.h.root);
            r_hn      <= NUM_W'(sq_end.side.lxy * sq_end.n.root);
            r_zn      <= NUM_W'(sq_end.side.zl * sq_end.n.root);
        end
    end

    // Stage 3: pick the binding limit, catch special cases and overflow.
    logic             r_s3_v;
    t_div             r_s3;
    t_div             n_s3;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             horiz;

    always_comb begin
        horiz = {r_cl, {FRAC_BITS{1'b0}}} < r_cr;
        num   = horiz ? r_hn : r_zn;
        den   = horiz ? r_h : DEN_W'({r_s2_side.az, {FRAC_BITS{1'b0}}});
        n_s3.rem  = num;
        n_s3.dsh  = DSH_W'({den, {(OUT_W-1){1'b0}}});
        n_s3.q    = '0;
        n_s3.spec = 1'b1;
        if (r_s2_side.res0) begin
            n_s3.sval = '0;
        end else if (r_h == '0) begin
            n_s3.sval = OUT_W'(r_s2_side.zl);
        end else if (r_s2_side.az0) begin
            n_s3.sval = OUT_W'(r_s2_side.lxy);
        end else if ((DEN_W+OUT_W)'(num) >= {den, {OUT_W{1'b0}}}) begin
            n_s3.sval = OUT_MAX;
        end else begin
            n_s3.sval = '0;
            n_s3.spec = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3 <= n_s3;
        end
    end

    // Divider chain: one quotient bit per cell.
    logic w_dv_v [0:OUT_W];
    t_div w_dv   [0:OUT_W];
    assign w_dv_v[0] = r_s3_v;
    assign w_dv[0]   = r_s3;

    for (genvar g = 0; g < OUT_W; g++) begin : g_div
        dkl_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_dv_v[g]),
            .i_data  (w_dv[g]),
            .o_valid (w_dv_v[g+1]),
            .o_data  (w_dv[g+1])
        );
    end

    // Output register plus skid.
    logic             pipe_v;
    logic [OUT_W-1:0] pipe_d;
    logic             r_ov;
    logic [OUT_W-1:0] r_od;
    logic [OUT_W-1:0] r_sd;
    logic             take;

    assign pipe_v = w_dv_v[OUT_W];
    assign pipe_d = w_dv[OUT_W].spec ? w_dv[OUT_W].sval : w_dv[OUT_W].q;
    assign take   = r_ov & o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || take) begin
            // Refill from the skid first, else from the pipe.
            r_ov <= r_sv | pipe_v;
            r_sv <= 1'b0;
        end else if (pipe_v && en) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || take) begin
            r_od <= r_sv ? r_sd : pipe_d;
        end else if (pipe_v && en) begin
            r_sd <= pipe_d;
        end
    end

    assign o_res.valid       = r_ov;
    assign o_res.limit_along = r_od;

    `DKL_ASSERT_IMP(a_skid_needs_out, r_sv, r_ov, "skid full with empty output register")
    `DKL_ASSERT_NXT(a_skid_catch, (pipe_v && en && r_ov && !o_res.ready), r_sv,
        "stalled result not caught by skid")
    `DKL_ASSERT_NXT(a_skid_hold, (r_sv && !o_res.ready), r_sv, "skid dropped while stalled")
    `DKL_ASSERT_IMP(a_out_fell_taken, $fell(r_ov), $past(o_res.ready),
        "result withdrawn without being taken")

endmodule

// File: rtl/dkl_sqrt_cell.sv
// One digit cell of the pipelined square root chain: one root bit per lane.
// Depends on dkl_pkg.
module dkl_sqrt_cell import dkl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_sq  i_data,
    output logic o_valid,
    output t_sq  o_data
);

    function automatic t_sq_lane lane_step(input t_sq_lane a);
        t_sq_lane         r;
        logic [REM_W+1:0] cur;
        logic [REM_W+1:0] trial;
        cur   = {a.rem, a.val[VAL_W-1 -: 2]};
        trial = (REM_W+2)'({a.root, 2'b01});
        r.val = {a.val[VAL_W-3:0], 2'b00};
        if (cur >= trial) begin
            r.rem  = REM_W'(cur - trial);
            r.root = {a.root[RT_W-2:0], 1'b1};
        end else begin
            r.rem  = cur[REM_W-1:0];
            r.root = {a.root[RT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic r_valid;
    t_sq  r_data;
    t_sq  n_data;

    always_comb begin
        n_data.h    = lane_step(i_data.h);
        n_data.n    = lane_step(i_data.n);
        n_data.side = i_data.side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/dkl_div_cell.sv
// One quotient-bit cell of the pipelined restoring divider chain.
// Depends on dkl_pkg.
module dkl_div_cell import dkl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_div i_data,
    output logic o_valid,
    output t_div o_data
);

    logic r_valid;
    t_div r_data;
    t_div n_data;

    always_comb begin
        n_data      = i_data;
        n_data.dsh  = i_data.dsh >> 1;
        if ({1'b0, i_data.rem} >= (NUM_W+1)'(i_data.dsh)) begin
            n_data.rem = NUM_W'({1'b0, i_data.rem} - (NUM_W+1)'(i_data.dsh));
            n_data.q   = {i_data.q[OUT_W-2:0], 1'b1};
        end else begin
            n_data.q   = {i_data.q[OUT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule
